// ===== src/bbc_pkg.sv =====
// Package: shared types and constants for the buffer cache.
package bbc_pkg;
  localparam int NUM_BUFFERS_DEF = 32;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_UNDER   = 2'd2,
    ST_SAT     = 2'd3
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] dev;
    logic [31:0] blk;
    logic [4:0]  idx;
    logic        idx_ok;
    logic [31:0] now;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SCAN,
    BS_SCAN_WAIT,
    BS_DECIDE,
    BS_IDX_RD,
    BS_IDX_DO
  } bstate_e;
endpackage

// ===== src/bbc_front.sv =====
// Front end: accepts commands, classifies index range, queues them.
module bbc_front #(
  parameter int NumBuffers = bbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [1:0]     op_i,
  input  logic [15:0]    dev_i,
  input  logic [31:0]    block_number_i,
  input  logic [4:0]     buf_index_i,
  input  logic [31:0]    now_tick_i,
  output logic           q_valid_o,
  output bbc_pkg::cmd_t  q_cmd_o,
  input  logic           q_pop_i
);
  import bbc_pkg::*;

  cmd_t q_q [QDEPTH];
  logic [$clog2(QDEPTH+1)-1:0] cnt_q, cnt_d;
  logic push;
  cmd_t c;

  assign busy_o = (cnt_q == QDEPTH[$clog2(QDEPTH+1)-1:0]);
  assign push   = start_i && !busy_o;

  always_comb begin
    c.op     = op_e'(op_i);
    c.dev    = dev_i;
    c.blk    = block_number_i;
    c.idx    = buf_index_i;
    c.idx_ok = ({27'd0, buf_index_i} < 32'(NumBuffers));
    c.now    = now_tick_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (push && (cnt_q == 0 || (cnt_q == 1 && q_pop_i))) q_q[0] <= c;
    else if (q_pop_i) q_q[0] <= q_q[1];
    if (push && cnt_q == 1 && !q_pop_i) q_q[1] <= c;
  end

  assign q_valid_o = (cnt_q != 0);
  assign q_cmd_o   = q_q[0];
endmodule

// ===== src/bbc_back.sv =====
// Back end: walks the buffer table for gets, updates counts and stamps.
module bbc_back #(
  parameter int NumBuffers = bbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  bbc_pkg::cmd_t  q_cmd_i,
  output logic           q_pop_o,
  output logic           done_o,
  output logic [1:0]     status_o,
  output logic [4:0]     entry_o,
  output logic           hit_o,
  output logic           need_read_o,
  output logic [7:0]     ref_count_o
);
  import bbc_pkg::*;
  localparam int IW = (NumBuffers > 1) ? $clog2(NumBuffers) : 1;
  localparam int CW = $clog2(NumBuffers + 1);

  logic [15:0] dev_m [NumBuffers];
  logic [31:0] blk_m [NumBuffers];
  logic [31:0] time_m [NumBuffers];
  logic [7:0]  refs_q [NumBuffers];
  logic        asg_q [NumBuffers];
  logic        vld_q [NumBuffers];

  bstate_e st_q, st_d;
  cmd_t    cmd_q;
  logic [CW-1:0] ptr_q;
  logic [IW-1:0] rd_idx_q;
  logic [15:0] rd_dev_q;
  logic [31:0] rd_blk_q, rd_time_q;
  logic        rd_go_q;
  logic        fnd_hit_q, fnd_free_q;
  logic [IW-1:0] hit_i_q, free_i_q;
  logic [31:0] oldest_q;

  logic [IW-1:0] ci;
  logic [7:0]    cref;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  assign ci   = (NumBuffers > 32) ? IW'(cmd_q.idx) : cmd_q.idx[IW-1:0];
  assign cref = refs_q[ci];

  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    rd_en   = 1'b0;
    rd_addr = ptr_q[IW-1:0];
    unique case (st_q)
      BS_IDLE: if (q_valid_i) begin
        q_pop_o = 1'b1;
        st_d = (q_cmd_i.op == OP_GET) ? BS_SCAN : BS_IDX_DO;
      end
      BS_SCAN: begin
        rd_en = 1'b1;
        if (ptr_q == CW'(NumBuffers - 1)) st_d = BS_SCAN_WAIT;
      end
      BS_SCAN_WAIT: st_d = BS_DECIDE;
      BS_DECIDE:    st_d = BS_IDLE;
      BS_IDX_RD:    st_d = BS_IDX_DO;
      BS_IDX_DO:    st_d = BS_IDLE;
      default:      st_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_dev_q  <= dev_m[rd_addr];
      rd_blk_q  <= blk_m[rd_addr];
      rd_time_q <= time_m[rd_addr];
    end
    rd_idx_q <= rd_addr;
    if (st_q == BS_IDLE && q_valid_i) cmd_q <= q_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BS_IDLE;
      ptr_q <= '0;
      rd_go_q <= 1'b0;
      fnd_hit_q <= 1'b0;
      fnd_free_q <= 1'b0;
      hit_i_q <= '0;
      free_i_q <= '0;
      oldest_q <= '0;
      done_o <= 1'b0;
      status_o <= '0;
      entry_o <= '0;
      hit_o <= 1'b0;
      need_read_o <= 1'b0;
      ref_count_o <= '0;
      for (int i = 0; i < NumBuffers; i++) begin
        refs_q[i] <= '0;
        asg_q[i] <= 1'b0;
        vld_q[i] <= 1'b0;
      end
    end else begin
      st_q <= st_d;
      done_o <= (st_q == BS_DECIDE) || (st_q == BS_IDX_DO);
      rd_go_q <= rd_en;
      if (st_q == BS_IDLE) begin
        ptr_q <= '0;
        fnd_hit_q <= 1'b0;
        fnd_free_q <= 1'b0;
      end
      if (rd_en) ptr_q <= ptr_q + 1'b1;
      if (rd_go_q) begin
        if (!fnd_hit_q && asg_q[rd_idx_q] && rd_dev_q == cmd_q.dev &&
            rd_blk_q == cmd_q.blk) begin
          fnd_hit_q <= 1'b1;
          hit_i_q <= rd_idx_q;
        end
        if (refs_q[rd_idx_q] == 8'd0 && (!fnd_free_q || rd_time_q < oldest_q)) begin
          fnd_free_q <= 1'b1;
          free_i_q <= rd_idx_q;
          oldest_q <= rd_time_q;
        end
      end
      if (st_q == BS_DECIDE) begin
        if (fnd_hit_q) begin
          entry_o <= 5'(hit_i_q);
          hit_o <= 1'b1;
          if (refs_q[hit_i_q] == 8'd255) begin
            status_o <= ST_SAT;
            need_read_o <= 1'b0;
            ref_count_o <= 8'd255;
          end else begin
            status_o <= ST_OK;
            need_read_o <= !vld_q[hit_i_q];
            ref_count_o <= refs_q[hit_i_q] + 8'd1;
            refs_q[hit_i_q] <= refs_q[hit_i_q] + 8'd1;
            vld_q[hit_i_q] <= 1'b1;
          end
        end else if (fnd_free_q) begin
          status_o <= ST_OK;
          entry_o <= 5'(free_i_q);
          hit_o <= 1'b0;
          need_read_o <= 1'b1;
          ref_count_o <= 8'd1;
          refs_q[free_i_q] <= 8'd1;
          asg_q[free_i_q] <= 1'b1;
          vld_q[free_i_q] <= 1'b1;
        end else begin
          status_o <= ST_NOFREE;
          entry_o <= '0;
          hit_o <= 1'b0;
          need_read_o <= 1'b0;
          ref_count_o <= '0;
        end
      end
      if (st_q == BS_IDX_DO) begin
        entry_o <= cmd_q.idx;
        hit_o <= 1'b0;
        need_read_o <= 1'b0;
        if (!cmd_q.idx_ok) begin
          status_o <= ST_OK;
          ref_count_o <= '0;
        end else if (cmd_q.op == OP_PIN) begin
          if (cref == 8'd255) begin
            status_o <= ST_SAT;
            ref_count_o <= 8'd255;
          end else begin
            status_o <= ST_OK;
            refs_q[ci] <= cref + 8'd1;
            ref_count_o <= cref + 8'd1;
          end
        end else if (cref == 8'd0) begin
          status_o <= ST_UNDER;
          ref_count_o <= '0;
        end else begin
          status_o <= ST_OK;
          refs_q[ci] <= cref - 8'd1;
          ref_count_o <= cref - 8'd1;
        end
      end
    end
  end

  // payload stores: written on grant and on release to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBuffers; i++) begin
        dev_m[i] <= '0;
        blk_m[i] <= '0;
        time_m[i] <= '0;
      end
    end else begin
      if (st_q == BS_DECIDE && !fnd_hit_q && fnd_free_q) begin
        dev_m[free_i_q] <= cmd_q.dev;
        blk_m[free_i_q] <= cmd_q.blk;
      end
      if (st_q == BS_IDX_DO && cmd_q.idx_ok && cmd_q.op == OP_RELEASE &&
          cref == 8'd1)
        time_m[ci] <= cmd_q.now;
    end
  end
endmodule

// ===== src/block_buffer_cache_lru_top.sv =====
// Top level: buffer cache with reference counts and timestamp LRU.
// channel | signals                                         | handshake
// command | op_i dev_i block_number_i buf_index_i now_tick_i | start_i && !busy_o
// result  | status_o entry_o hit_o need_read_o ref_count_o  | done_o, one cycle
// A get examines one table entry per cycle in BS_SCAN, then passes BS_SCAN_WAIT and BS_DECIDE.
// Release, pin and unpin go from BS_IDLE to BS_IDX_DO and back. A two-entry queue decouples intake.
// Reset clears all entries at once. The receiver cannot stall results.
module block_buffer_cache_lru_top #(
  parameter int NumBuffers = bbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] dev_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  buf_index_i,
  input  logic [31:0] now_tick_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_o,
  output logic        hit_o,
  output logic        need_read_o,
  output logic [7:0]  ref_count_o
);
  import bbc_pkg::*;
  logic qv, qp;
  cmd_t qc;

  bbc_front #(.NumBuffers(NumBuffers)) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .dev_i, .block_number_i,
    .buf_index_i, .now_tick_i, .q_valid_o(qv), .q_cmd_o(qc), .q_pop_i(qp)
  );

  bbc_back #(.NumBuffers(NumBuffers)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_cmd_i(qc), .q_pop_o(qp),
    .done_o, .status_o, .entry_o, .hit_o, .need_read_o, .ref_count_o
  );
endmodule

// ===== src/bbc_checker.sv =====
// Checker: port-level properties of the buffer cache top level.
module bbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic [4:0] entry_o,
  input logic       hit_o,
  input logic       need_read_o,
  input logic [7:0] ref_count_o
);
  import bbc_pkg::*;
  a_nofree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_NOFREE |-> entry_o == 0 && !hit_o && ref_count_o == 0)
    else $error("no-free result not cleared");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_SAT |-> ref_count_o == 8'd255 && !need_read_o)
    else $error("saturated result wrong");
  a_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_UNDER |-> ref_count_o == 0 && !hit_o)
    else $error("underflow result wrong");
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && need_read_o && !hit_o |-> ref_count_o == 8'd1)
    else $error("recycled entry count wrong");
endmodule

bind block_buffer_cache_lru_top bbc_checker u_chk (.*);

// ===== tb/block_buffer_cache_lru_top_tb.sv =====
// Testbench for the buffer cache: directed table plus random traffic, checked by a predictor.
`timescale 1ns / 1ps
module block_buffer_cache_lru_top_tb;
  import bbc_pkg::*;

  localparam int NB = 32;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  entry;
    logic        hit;
    logic        need_read;
    logic [7:0]  ref_count;
  } cache_res_t;

  typedef struct {
    op_e         op;
    logic [15:0] dev;
    logic [31:0] blk;
    logic [4:0]  idx;
    logic [31:0] now;
    bit          known;
    cache_res_t  res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] op_i = '0;
  logic [15:0] dev_i = '0;
  logic [31:0] block_number_i = '0;
  logic [4:0] buf_index_i = '0;
  logic [31:0] now_tick_i = '0;
  logic busy_o, done_o, hit_o, need_read_o;
  logic [1:0] status_o;
  logic [4:0] entry_o;
  logic [7:0] ref_count_o;

  block_buffer_cache_lru_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [15:0] m_dev [NB];
  logic [31:0] m_blk [NB];
  logic [7:0]  m_refs [NB];
  logic [31:0] m_time [NB];
  bit          m_valid [NB];
  bit          m_assigned [NB];

  cache_res_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_get = 0;
  int n_hit = 0;
  int n_nofree = 0;
  int send_idle = 38;

  function automatic cache_res_t mk(logic [1:0] st, logic [4:0] e, logic h, logic r,
                                    logic [7:0] c);
    cache_res_t x;
    x.status = st; x.entry = e; x.hit = h; x.need_read = r; x.ref_count = c;
    return x;
  endfunction

  function automatic cache_res_t cache_predict(op_e op, logic [15:0] dev, logic [31:0] blk,
                                               logic [4:0] idx, logic [31:0] now);
    int pick;
    logic [31:0] oldest;
    pick = -1;
    oldest = '0;
    if (op == OP_GET) begin
      for (int i = 0; i < NB; i++)
        if (m_assigned[i] && m_dev[i] == dev && m_blk[i] == blk) begin
          if (m_refs[i] == 8'hff) return mk(ST_SAT, 5'(i), 1'b1, 1'b0, 8'hff);
          m_refs[i]++;
          cache_predict = mk(ST_OK, 5'(i), 1'b1, !m_valid[i], m_refs[i]);
          m_valid[i] = 1;
          return cache_predict;
        end
      for (int i = 0; i < NB; i++)
        if (m_refs[i] == 0 && (pick < 0 || m_time[i] < oldest)) begin
          pick = i;
          oldest = m_time[i];
        end
      if (pick < 0) return mk(ST_NOFREE, 0, 0, 0, 0);
      m_dev[pick] = dev; m_blk[pick] = blk; m_refs[pick] = 1;
      m_assigned[pick] = 1; m_valid[pick] = 1;
      return mk(ST_OK, 5'(pick), 1'b0, 1'b1, 8'd1);
    end
    if (op == OP_PIN) begin
      if (m_refs[idx] == 8'hff) return mk(ST_SAT, idx, 0, 0, 8'hff);
      m_refs[idx]++;
    end else begin
      if (m_refs[idx] == 0) return mk(ST_UNDER, idx, 0, 0, 0);
      m_refs[idx]--;
      if (op == OP_RELEASE && m_refs[idx] == 0) m_time[idx] = now;
    end
    return mk(ST_OK, idx, 0, 0, m_refs[idx]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d want %0d", n_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      cache_res_t w;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, queue size", 0, 1);
      end else begin
        w = expected_q.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (entry_o !== w.entry) report_mismatch("entry", entry_o, w.entry);
        if (hit_o !== w.hit) report_mismatch("hit", hit_o, w.hit);
        if (need_read_o !== w.need_read) report_mismatch("need_read", need_read_o, w.need_read);
        if (ref_count_o !== w.ref_count) report_mismatch("ref_count", ref_count_o, w.ref_count);
      end
      n_seen++;
    end
  end

  task automatic send_cmd(op_e op, logic [15:0] dev, logic [31:0] blk, logic [4:0] idx,
                          logic [31:0] now, bit known, cache_res_t want);
    cache_res_t p;
    while ($urandom_range(99) < send_idle) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op; dev_i <= dev; block_number_i <= blk; buf_index_i <= idx; now_tick_i <= now;
    do @(posedge clk_i); while (busy_o);
    p = cache_predict(op, dev, blk, idx, now);
    if (known && (p.status !== want.status || p.entry !== want.entry || p.hit !== want.hit ||
                  p.need_read !== want.need_read || p.ref_count !== want.ref_count))
      report_mismatch("table row vs predictor, status", p.status, want.status);
    expected_q.push_back(p);
    if (op == OP_GET) begin
      n_get++;
      if (p.hit) n_hit++;
      if (p.status == ST_NOFREE) n_nofree++;
    end
    n_sent++;
  endtask

  stim_row_t dir_tab[$];

  task automatic add_row(op_e op, logic [15:0] d, logic [31:0] b, logic [4:0] i,
                         logic [31:0] t, bit k, cache_res_t r);
    stim_row_t s;
    s.op = op; s.dev = d; s.blk = b; s.idx = i; s.now = t; s.known = k; s.res = r;
    dir_tab.push_back(s);
  endtask

  initial begin
    cache_res_t z;
    op_e op;
    logic [15:0] d;
    logic [31:0] b;
    int tick;
    z = mk(0, 0, 0, 0, 0);
    for (int i = 0; i < NB; i++) begin
      m_dev[i] = 0; m_blk[i] = 0; m_refs[i] = 0; m_time[i] = 0;
      m_valid[i] = 0; m_assigned[i] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // never-assigned entry 0 with zero key must not hit
    add_row(OP_GET, 16'h0, 32'h0, 0, 0, 1, mk(ST_OK, 0, 0, 1, 1));
    add_row(OP_GET, 16'hffff, 32'hffffffff, 0, 0, 1, mk(ST_OK, 1, 0, 1, 1));
    add_row(OP_GET, 16'hffff, 32'hffffffff, 0, 0, 1, mk(ST_OK, 1, 1, 0, 2));
    add_row(OP_UNPIN, 0, 0, 5'd31, 0, 1, mk(ST_UNDER, 31, 0, 0, 0));
    add_row(OP_RELEASE, 0, 0, 5'd30, 0, 1, mk(ST_UNDER, 30, 0, 0, 0));
    add_row(OP_PIN, 0, 0, 5'd31, 0, 1, mk(ST_OK, 31, 0, 0, 1));
    add_row(OP_UNPIN, 0, 0, 5'd31, 32'hffffffff, 1, mk(ST_OK, 31, 0, 0, 0));
    add_row(OP_RELEASE, 0, 0, 5'd0, 32'hffffffff, 1, mk(ST_OK, 0, 0, 0, 0));
    add_row(OP_RELEASE, 0, 0, 5'd1, 32'h5, 0, z);
    add_row(OP_RELEASE, 0, 0, 5'd1, 32'h5, 0, z);
    add_row(OP_GET, 16'h1234, 32'h0, 0, 0, 0, z);
    add_row(OP_GET, 16'h0, 32'h0, 0, 0, 0, z);
    foreach (dir_tab[k])
      send_cmd(dir_tab[k].op, dir_tab[k].dev, dir_tab[k].blk, dir_tab[k].idx,
               dir_tab[k].now, dir_tab[k].known, dir_tab[k].res);
    // drive entry 2 to saturation, then pin and get at full count
    for (int k = 0; k < 256; k++) begin
      send_idle = 0;
      send_cmd(OP_PIN, 0, 0, 5'd2, 0, 0, z);
    end
    send_cmd(OP_GET, m_dev[2], m_blk[2], 0, 0, 0, z);
    // fill every entry, then a miss finds no free buffer
    for (int k = 0; k < NB; k++) send_cmd(OP_PIN, 0, 0, 5'(k), 0, 0, z);
    send_cmd(OP_GET, 16'hbeef, 32'hdead, 0, 0, 1, mk(ST_NOFREE, 0, 0, 0, 0));
    for (int k = 0; k < NB; k++) send_cmd(OP_UNPIN, 0, 0, 5'(k), 0, 0, z);

    tick = 0;
    for (int k = 0; k < 616; k++) begin
      send_idle = (k < 205) ? 38 : (k < 410) ? 61 : 0;
      tick += $urandom_range(3);
      case ($urandom_range(9))
        0, 1, 2, 3: op = OP_GET;
        4, 5, 6: op = OP_RELEASE;
        7: op = OP_PIN;
        default: op = OP_UNPIN;
      endcase
      if ($urandom_range(9) == 0) begin
        d = 16'($urandom); b = $urandom;
      end else begin
        d = 16'($urandom_range(3)); b = $urandom_range(11);
        if ($urandom_range(1)) begin d = ~d; b = ~b; end
      end
      send_cmd(op, d, b, 5'($urandom), ($urandom_range(7) == 0) ? $urandom : tick, 0, z);
    end
    start_i <= 1'b0;

    fork
      begin
        wait (expected_q.size() == 0);
        repeat (50) @(posedge clk_i);
      end
    join
    $display("sent %0d transactions, checked %0d results", n_sent, n_seen);
    $display("gets %0d, hits %0d, no-free %0d", n_get, n_hit, n_nofree);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[block_buffer_cache_lru_top] OK");
    end else begin
      $display("[block_buffer_cache_lru_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[block_buffer_cache_lru_top] ERROR");
    $finish;
  end
endmodule
